FILE: hdl/edd_pkg.sv
// Shared types, constants and helper functions of the error diffusion dither core.
`timescale 1ns / 1ps

package edd_pkg;

    // Line store geometry
    localparam int LINE_MAX = 1024;
    localparam int COL_W    = $clog2(LINE_MAX);

    // Field and register widths
    localparam int LUMA_W = 12;
    localparam int LW_W   = 11;
    localparam int FH_W   = 12;
    localparam int ROW_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Width used to compare the line width against the store depth
    localparam int CMP_W = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

    // Error arithmetic, all in 1/256 units
    localparam int ERR_W  = 18;
    localparam int SUM_W  = 19;
    localparam int PROD_W = 22;

    localparam logic signed [SUM_W-1:0] THRESH_UNITS = SUM_W'(32768);
    localparam logic signed [SUM_W-1:0] FULL_UNITS   = SUM_W'(65280);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_idx_t;

    typedef logic signed [ERR_W-1:0] err_t;

    // Raster position of the pixel under work
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             last_row;
    } pos_t;

    // Saturate a one-bit-grown sum back to the error width
    function automatic err_t sat_err(input logic signed [ERR_W:0] v);
        err_t r;
        if (v[ERR_W] != v[ERR_W-1]) begin
            r = v[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

    // (e * w + 8) / 16 with floor, i.e. round to nearest, ties up
    function automatic err_t weigh(input logic signed [SUM_W-1:0] e, input logic [2:0] w);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(e) * $signed({1'b0, w}) + PROD_W'(8);
        return p[PROD_W-1:4];
    endfunction

endpackage

FILE: hdl/edd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module edd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read (read returns the old contents)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/edd_raster.sv
// Raster position tracking: column and row counters with width and height clamping.
`timescale 1ns / 1ps

module edd_raster (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [edd_pkg::LW_W-1:0]   line_width,
    input  logic [edd_pkg::FH_W-1:0]   frame_height,
    input  logic                       advance,
    output edd_pkg::pos_t              pos,
    output logic [edd_pkg::COL_W-1:0]  next_col
);

    logic [edd_pkg::COL_W-1:0] column_count_reg, column_count_next;
    logic [edd_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    logic [edd_pkg::CMP_W-1:0] lw_ext, lw_eff;
    logic [edd_pkg::COL_W-1:0] wm1;
    logic [edd_pkg::FH_W-1:0]  hm1;

    // Effective width: zero acts as one, above the store depth acts as the depth
    always_comb begin
        lw_ext = edd_pkg::CMP_W'(line_width);
        if (lw_ext == '0) begin
            lw_eff = edd_pkg::CMP_W'(1);
        end else if (lw_ext > edd_pkg::CMP_W'(edd_pkg::LINE_MAX)) begin
            lw_eff = edd_pkg::CMP_W'(edd_pkg::LINE_MAX);
        end else begin
            lw_eff = lw_ext;
        end
        wm1 = edd_pkg::COL_W'(lw_eff - edd_pkg::CMP_W'(1));
        hm1 = (frame_height == '0) ? '0 : frame_height - 1'b1;
    end

    // Position of the current pixel
    always_comb begin
        pos.col      = (column_count_reg > wm1) ? wm1 : column_count_reg;
        pos.last_col = (column_count_reg >= wm1);
        pos.last_row = (row_count_reg >= hm1);
        next_col     = pos.last_col ? '0 : pos.col + 1'b1;
    end

    // Counter update
    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (advance) begin
            column_count_next = next_col;
            if (pos.last_col) begin
                row_count_next = pos.last_row ? '0 : row_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

FILE: hdl/edd_diffuse.sv
// Threshold and error spreading for one pixel, with the in-row error registers.
`timescale 1ns / 1ps

module edd_diffuse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [edd_pkg::LUMA_W-1:0]  luma,
    input  edd_pkg::err_t               store_err,
    input  edd_pkg::pos_t               pos,
    output logic                        dot,
    output edd_pkg::err_t               left_wr_data,
    output edd_pkg::err_t               tail_wr_data
);

    edd_pkg::err_t right_carry_reg, right_carry_next;
    edd_pkg::err_t below_left_reg, below_left_next;
    edd_pkg::err_t below_reg, below_next;

    edd_pkg::err_t                    pending;
    logic signed [edd_pkg::SUM_W-1:0] sum, err;
    edd_pkg::err_t                    r7, r3, r5, r1, blp_new;

    // Pending error, threshold and residual
    always_comb begin
        pending = edd_pkg::sat_err({right_carry_reg[edd_pkg::ERR_W-1], right_carry_reg}
                                   + {store_err[edd_pkg::ERR_W-1], store_err});
        sum = $signed({{(edd_pkg::SUM_W - edd_pkg::LUMA_W - 4){1'b0}}, luma, 4'b0000})
              + edd_pkg::SUM_W'(pending);
        dot = (sum > edd_pkg::THRESH_UNITS);
        err = dot ? sum - edd_pkg::FULL_UNITS : sum;
    end

    // Weighted terms, dropped at the image edges
    always_comb begin
        r7 = pos.last_col ? '0 : edd_pkg::weigh(err, 3'd7);
        r3 = (pos.last_row || pos.col == '0) ? '0 : edd_pkg::weigh(err, 3'd3);
        r5 = pos.last_row ? '0 : edd_pkg::weigh(err, 3'd5);
        r1 = (pos.last_row || pos.last_col) ? '0 : edd_pkg::weigh(err, 3'd1);

        left_wr_data = edd_pkg::sat_err({below_left_reg[edd_pkg::ERR_W-1], below_left_reg}
                                        + {r3[edd_pkg::ERR_W-1], r3});
        blp_new      = edd_pkg::sat_err({below_reg[edd_pkg::ERR_W-1], below_reg}
                                        + {r5[edd_pkg::ERR_W-1], r5});
        tail_wr_data = blp_new;
    end

    // Error register update; a row end clears them
    always_comb begin
        right_carry_next = right_carry_reg;
        below_left_next  = below_left_reg;
        below_next       = below_reg;
        if (advance) begin
            if (pos.last_col) begin
                right_carry_next = '0;
                below_left_next  = '0;
                below_next       = '0;
            end else begin
                right_carry_next = r7;
                below_left_next  = blp_new;
                below_next       = r1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_carry_reg <= '0;
            below_left_reg  <= '0;
            below_reg       <= '0;
        end else begin
            right_carry_reg <= right_carry_next;
            below_left_reg  <= below_left_next;
            below_reg       <= below_next;
        end
    end

endmodule

FILE: hdl/error_diffusion_dither_core.sv
// Top level of the 1-bit error diffusion dither core.
//
//   Channel   Direction  Handshake               Payload
//   s_        in         s_valid / s_ready       s_luma (12b, unsigned 8.4)
//   m_        out        m_valid / m_ready       m_dot, m_row_end, m_frame_end
//   cfg_      in         cfg_valid / cfg_ready   cfg_index (2b), cfg_data (12b)
//
// One pixel per clock sustained after the clearing pass while m_ready is high; a
// pixel passes through the input register and then the result register.
// The line store read is issued as a pixel enters the input register; the one
// write per pixel past column 0 and a deferred row-end write share the store's
// single write port. After reset a clearing pass writes zeros to all LINE_MAX
// store entries with s_ready low; configuration writes are taken throughout.
// A stalled result holds the input register, which then holds s_ready low.
`timescale 1ns / 1ps

module error_diffusion_dither_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [edd_pkg::LUMA_W-1:0]      s_luma,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_dot,
    output logic                            m_row_end,
    output logic                            m_frame_end,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [edd_pkg::LW_W-1:0] line_width_reg;
    logic [edd_pkg::FH_W-1:0] frame_height_reg;

    logic                        s1_valid_reg;
    logic [edd_pkg::LUMA_W-1:0]  s1_luma_reg;
    logic                        s1_adv, s_accept;

    logic m_valid_reg, m_dot_reg, m_row_end_reg, m_frame_end_reg;

    logic                        clear_active_reg;
    logic [edd_pkg::COL_W-1:0]   clear_cnt_reg;

    logic                        def_valid_reg;
    logic [edd_pkg::COL_W-1:0]   def_addr_reg;
    edd_pkg::err_t               def_data_reg;

    logic                        lw_valid_reg;
    logic [edd_pkg::COL_W-1:0]   lw_addr_reg;
    edd_pkg::err_t               lw_data_reg;

    edd_pkg::pos_t               pos;
    logic [edd_pkg::COL_W-1:0]   next_col;
    logic [edd_pkg::COL_W-1:0]   rd_addr, wr_addr;
    logic                        wr_en;
    edd_pkg::err_t               wr_data, rd_data, store_err;
    edd_pkg::err_t               left_wr_data, tail_wr_data;
    logic                        dot;

    // Handshake control
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clear_active_reg && (!s1_valid_reg || s1_adv);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= edd_pkg::LW_W'(200);
            frame_height_reg <= edd_pkg::FH_W'(8);
        end else if (cfg_valid) begin
            case (cfg_index)
                edd_pkg::CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[edd_pkg::LW_W-1:0];
                edd_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[edd_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    edd_raster u_raster (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .advance      (s1_adv),
        .pos          (pos),
        .next_col     (next_col)
    );

    // Store read: address of the pixel that sits in, or is entering, the input register
    assign rd_addr = s1_adv ? next_col : pos.col;

    // Read data forwarding: the deferred write is newest, then the last write done
    always_comb begin
        if (def_valid_reg && def_addr_reg == pos.col) begin
            store_err = def_data_reg;
        end else if (lw_valid_reg && lw_addr_reg == pos.col) begin
            store_err = lw_data_reg;
        end else begin
            store_err = rd_data;
        end
    end

    edd_diffuse u_diffuse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s1_adv),
        .luma         (s1_luma_reg),
        .store_err    (store_err),
        .pos          (pos),
        .dot          (dot),
        .left_wr_data (left_wr_data),
        .tail_wr_data (tail_wr_data)
    );

    // Store write port: clearing pass, deferred row-end write, or left neighbor
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos.col - 1'b1;
        wr_data = left_wr_data;
        if (clear_active_reg) begin
            wr_en   = 1'b1;
            wr_addr = clear_cnt_reg;
            wr_data = '0;
        end else if (def_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = def_addr_reg;
            wr_data = def_data_reg;
        end else if (s1_adv && pos.col != '0) begin
            wr_en = 1'b1;
        end
    end

    edd_ram #(
        .WIDTH (edd_pkg::ERR_W),
        .DEPTH (edd_pkg::LINE_MAX)
    ) u_line_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
        end else if (clear_active_reg) begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == edd_pkg::COL_W'(edd_pkg::LINE_MAX - 1)) begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // Deferred row-end write and last-write record for forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end else begin
            def_valid_reg <= s1_adv && pos.last_col;
            lw_valid_reg  <= wr_en;
        end
        def_addr_reg <= pos.col;
        def_data_reg <= tail_wr_data;
        lw_addr_reg  <= wr_addr;
        lw_data_reg  <= wr_data;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            s1_luma_reg <= s_luma;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (s1_adv) begin
            m_dot_reg       <= dot;
            m_row_end_reg   <= pos.last_col;
            m_frame_end_reg <= pos.last_col && pos.last_row;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_dot       = m_dot_reg;
    assign m_row_end   = m_row_end_reg;
    assign m_frame_end = m_frame_end_reg;

    // No pixel enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_active_reg |-> !s_ready)
        else $error("pixel transfer during store clearing pass");

    // A deferred row-end write is always followed by a first-column pixel
    a_def_at_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        def_valid_reg |-> (pos.col == '0))
        else $error("deferred store write collides with a pixel write");

    // A row-end pixel leaving the input register is always followed by a deferred write
    a_def_after_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && pos.last_col) |=> def_valid_reg)
        else $error("row-end store write was not deferred");

    // Frame end is only flagged on a row end
    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_frame_end_reg) |-> m_row_end_reg)
        else $error("frame end without row end");

endmodule

FILE: test/error_diffusion_dither_core_tb.sv
// Self-checking testbench for the error diffusion dither core: directed table, then random frames.
`timescale 1ns / 1ps

module error_diffusion_dither_core_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RAND_ITEMS   = 1600;
    localparam int DRAIN_CYCLES = 6;
    // 4 ms is far beyond the clearing pass plus every pixel at its worst stalls
    localparam int RUN_LIMIT_NS = 4_000_000;

    // Error arithmetic in 1/256 units
    localparam int ERR_HI    = 2 ** (edd_pkg::ERR_W - 1) - 1;
    localparam int ERR_LO    = -(2 ** (edd_pkg::ERR_W - 1));
    localparam int LIT_ABOVE = 32768;   // 128.0
    localparam int LIT_LEVEL = 65280;   // 255.0

    // Register index with no register behind it
    localparam logic [edd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic dot;
        logic row_end;
        logic frame_end;
    } dot_res_t;

    // One row of the directed table: either a register write or a pixel
    typedef struct packed {
        logic                           is_cfg;
        logic                           typed;
        logic [edd_pkg::CFG_IDX_W-1:0]  idx;
        logic [edd_pkg::CFG_DATA_W-1:0] val;
        dot_res_t                       want;
    } drill_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [edd_pkg::LUMA_W-1:0]     s_luma;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_dot;
    logic                           m_row_end;
    logic                           m_frame_end;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [edd_pkg::CFG_DATA_W-1:0] cfg_data;

    error_diffusion_dither_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_luma      (s_luma),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dot       (m_dot),
        .m_row_end   (m_row_end),
        .m_frame_end (m_frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Dither state mirrored on the testbench side
    int line_err [edd_pkg::LINE_MAX];
    int carry_err;
    int bl_err;
    int b_err;
    int col_pos;
    int row_pos;
    int width_reg;
    int height_reg;

    dot_res_t   dots_due [$];
    drill_row_t drill [$];
    int         mismatches;
    bit         src_busy;
    bit         snk_busy;

    function automatic int clamp_err(input int v);
        if (v < ERR_LO) return ERR_LO;
        if (v > ERR_HI) return ERR_HI;
        return v;
    endfunction

    // Weighted share of an error, rounded to nearest with ties upward (floor of +8)
    function automatic int share(input int e, input int wt);
        return (e * wt + 8) >>> 4;
    endfunction

    // Dithers one pixel against the mirrored state and advances it
    function automatic dot_res_t dither_pixel(input logic [edd_pkg::LUMA_W-1:0] luma);
        int       w;
        int       h;
        int       col;
        int       pend;
        int       sum;
        int       err;
        int       r7;
        int       r3;
        int       r5;
        int       r1;
        logic     last_col;
        logic     last_row;
        logic     lit;
        dot_res_t r;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > edd_pkg::LINE_MAX) w = edd_pkg::LINE_MAX;
        h = height_reg;
        if (h == 0) h = 1;

        // a shrunk width or height mid-frame ends the row or frame at once
        col      = (col_pos > w - 1) ? w - 1 : col_pos;
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);

        pend = clamp_err(carry_err + line_err[col]);
        sum  = int'(luma) * 16 + pend;
        lit  = (sum > LIT_ABOVE);
        err  = lit ? sum - LIT_LEVEL : sum;

        // weights falling outside the image are dropped
        r7 = last_col ? 0 : share(err, 7);
        r3 = (last_row || col == 0) ? 0 : share(err, 3);
        r5 = last_row ? 0 : share(err, 5);
        r1 = (last_row || last_col) ? 0 : share(err, 1);

        if (col > 0) line_err[col - 1] = clamp_err(bl_err + r3);
        bl_err    = clamp_err(b_err + r5);
        b_err     = clamp_err(r1);
        carry_err = clamp_err(r7);

        if (last_col) begin
            line_err[col] = bl_err;
            bl_err    = 0;
            b_err     = 0;
            carry_err = 0;
            col_pos   = 0;
            row_pos   = last_row ? 0 : (row_pos + 1) & 12'hFFF;
        end else begin
            col_pos = col + 1;
        end

        r.dot       = lit;
        r.row_end   = last_col;
        r.frame_end = last_col && last_row;
        return r;
    endfunction

    function automatic logic [edd_pkg::LUMA_W-1:0] pick_luma(input int style, input int base);
        int v;
        case (style)
            0: v = $urandom_range(0, 4095);
            1: begin
                // extremes mixed into noise
                case ($urandom_range(0, 3))
                    0:       v = 0;
                    1:       v = 4095;
                    default: v = $urandom_range(0, 4095);
                endcase
            end
            2: v = 2040 + int'($urandom_range(0, 16));
            default: v = base + int'($urandom_range(0, 15)) - 8;   // flat field
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[edd_pkg::LUMA_W-1:0];
    endfunction

    task automatic drill_cfg(input logic [edd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [edd_pkg::CFG_DATA_W-1:0] val);
        drill.push_back('{is_cfg: 1'b1, typed: 1'b0, idx: idx, val: val, want: '0});
    endtask

    task automatic drill_pix(input logic [edd_pkg::LUMA_W-1:0] luma, input logic typed,
                             input dot_res_t want);
        drill.push_back('{is_cfg: 1'b0, typed: typed, idx: edd_pkg::CFG_LINE_WIDTH,
                          val: edd_pkg::CFG_DATA_W'(luma), want: want});
    endtask

    // Register write transfer; called at a falling edge, returns at one
    task automatic write_reg(input logic [edd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [edd_pkg::CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            edd_pkg::CFG_LINE_WIDTH:   width_reg  = int'(data[edd_pkg::LW_W-1:0]);
            edd_pkg::CFG_FRAME_HEIGHT: height_reg = int'(data[edd_pkg::FH_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Pixel transfer; valid stays high on return so back-to-back pixels need no gap
    task automatic push_pixel(input logic [edd_pkg::LUMA_W-1:0] luma, input logic typed,
                              input dot_res_t want);
        int       gap;
        dot_res_t model_res;
        gap = src_busy ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_luma  = luma;
        do @(posedge aclk); while (s_ready !== 1'b1);
        model_res = dither_pixel(luma);
        dots_due.push_back(typed ? want : model_res);
        @(negedge aclk);
    endtask

    // Block is idle once every pending result is out and the pipeline has flushed
    task automatic wait_idle();
        s_valid = 1'b0;
        while (dots_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Result side: random stalls, each transfer checked against the oldest expectation
    initial begin : result_sink
        int       gap;
        dot_res_t want;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = snk_busy ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (dots_due.size() == 0) begin
                $error("result transfer with no pixel outstanding");
                mismatches++;
            end else begin
                want = dots_due.pop_front();
                if (m_dot !== want.dot) begin
                    $error("dot: expected %0b, got %0b", want.dot, m_dot);
                    mismatches++;
                end
                if (m_row_end !== want.row_end) begin
                    $error("row_end: expected %0b, got %0b", want.row_end, m_row_end);
                    mismatches++;
                end
                if (m_frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, m_frame_end);
                    mismatches++;
                end
            end
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int                             n_sent;
        int                             n_phase;
        int                             eff_w;
        int                             style;
        int                             base;
        logic [edd_pkg::CFG_DATA_W-1:0] lw_val;
        logic [edd_pkg::CFG_DATA_W-1:0] fh_val;
        drill_row_t                     row;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_luma     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = edd_pkg::CFG_LINE_WIDTH;
        cfg_data   = '0;
        mismatches = 0;
        src_busy   = 1'b1;
        snk_busy   = 1'b1;

        // state after reset: cleared store, 200 x 8 grid
        foreach (line_err[i]) line_err[i] = 0;
        carry_err  = 0;
        bl_err     = 0;
        b_err      = 0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = 200;
        height_reg = 8;

        // Directed table. Typed rows: {dot, row_end, frame_end}.
        // First pixel after reset sees a clean store
        drill_pix(12'd4095, 1'b1, 3'b100);
        drill_pix(12'd0,    1'b0, '0);
        drill_pix(12'd2048, 1'b0, '0);
        drill_pix(12'd2049, 1'b0, '0);
        // Shrink to 1 x 1 mid-row; leftover error drains over two pixels,
        // after that the dot is lit exactly above 128.0
        drill_cfg(edd_pkg::CFG_LINE_WIDTH,   12'd1);
        drill_cfg(edd_pkg::CFG_FRAME_HEIGHT, 12'd1);
        drill_pix(12'd0,    1'b0, '0);
        drill_pix(12'd4095, 1'b0, '0);
        drill_pix(12'd2048, 1'b1, 3'b011);
        drill_pix(12'd2049, 1'b1, 3'b111);
        drill_pix(12'd4095, 1'b1, 3'b111);
        drill_pix(12'd0,    1'b1, 3'b011);
        // Zero width (only the unused top bit set) and zero height act as 1
        drill_cfg(edd_pkg::CFG_LINE_WIDTH,   12'h800);
        drill_cfg(edd_pkg::CFG_FRAME_HEIGHT, 12'd0);
        drill_pix(12'd4095, 1'b1, 3'b111);
        drill_pix(12'd2048, 1'b1, 3'b011);
        // Write to an unused index changes nothing
        drill_cfg(CFG_SPARE, 12'hFFF);
        drill_pix(12'd2049, 1'b1, 3'b111);
        // Width above the store depth clamps to it; tallest frame
        drill_cfg(edd_pkg::CFG_LINE_WIDTH,   12'd2047);
        drill_cfg(edd_pkg::CFG_FRAME_HEIGHT, 12'd4095);
        drill_pix(12'd4095, 1'b1, 3'b100);
        drill_pix(12'd0,    1'b0, '0);
        drill_pix(12'd1000, 1'b0, '0);
        // Narrow 3 x 2 frame entered past its last column
        drill_cfg(edd_pkg::CFG_LINE_WIDTH,   12'd3);
        drill_cfg(edd_pkg::CFG_FRAME_HEIGHT, 12'd2);
        drill_pix(12'd4095, 1'b0, '0);
        drill_pix(12'd0,    1'b0, '0);
        drill_pix(12'd4095, 1'b0, '0);
        drill_pix(12'd2048, 1'b0, '0);
        drill_pix(12'd0,    1'b0, '0);
        drill_pix(12'd4095, 1'b0, '0);
        drill_pix(12'd1,    1'b0, '0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (drill[k]) begin
            row = drill[k];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.idx, row.val);
            end else begin
                push_pixel(row.val[edd_pkg::LUMA_W-1:0], row.typed, row.want);
            end
        end

        // Random phases: new grid size each time, frames often cut off mid-row
        n_sent = 0;
        while (n_sent < RAND_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0: lw_val = edd_pkg::CFG_DATA_W'(edd_pkg::LINE_MAX);
                1: lw_val = edd_pkg::CFG_DATA_W'($urandom_range(edd_pkg::LINE_MAX + 1, 2047));
                2: lw_val = edd_pkg::CFG_DATA_W'($urandom_range(0, 1));
                default: lw_val = edd_pkg::CFG_DATA_W'($urandom_range(2, 24));
            endcase
            if ($urandom_range(0, 7) == 0) lw_val[edd_pkg::LW_W] = 1'b1;
            case ($urandom_range(0, 7))
                0:       fh_val = edd_pkg::CFG_DATA_W'(4095);
                1:       fh_val = '0;
                2:       fh_val = edd_pkg::CFG_DATA_W'(1);
                default: fh_val = edd_pkg::CFG_DATA_W'($urandom_range(2, 6));
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_reg(edd_pkg::CFG_LINE_WIDTH, lw_val);
                write_reg(edd_pkg::CFG_FRAME_HEIGHT, fh_val);
            end else begin
                write_reg(edd_pkg::CFG_FRAME_HEIGHT, fh_val);
                write_reg(edd_pkg::CFG_LINE_WIDTH, lw_val);
            end
            if ($urandom_range(0, 9) == 0) begin
                write_reg(CFG_SPARE, edd_pkg::CFG_DATA_W'($urandom));
            end

            // wide rows get long phases so that some reach a row end
            eff_w   = int'(lw_val[edd_pkg::LW_W-1:0]);
            n_phase = (eff_w > 64) ? $urandom_range(50, 1100) : $urandom_range(20, 150);
            if (n_phase > RAND_ITEMS - n_sent) n_phase = RAND_ITEMS - n_sent;
            style    = $urandom_range(0, 3);
            base     = $urandom_range(0, 4095);
            src_busy = ($urandom_range(0, 3) != 0);
            snk_busy = ($urandom_range(0, 3) != 0);
            repeat (n_phase) push_pixel(pick_luma(style, base), 1'b0, '0);
            n_sent += n_phase;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("error_diffusion_dither_core_tb: PASS");
        end else begin
            $display("error_diffusion_dither_core_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #RUN_LIMIT_NS;
        $display("error_diffusion_dither_core_tb: FAIL");
        $finish;
    end

endmodule
